// ===== sv/ecgpr_pkg.sv =====
package ecgpr_pkg;

    // default parameter values
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // field widths
    localparam int THR_W       = 32;
    localparam int BPM_W       = 18;
    localparam int RATE_CFG_W  = 13;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - BPM_W - THR_W;

    // 60 * sample_rate needs 19 bits
    localparam int RATE_SCALE = 60;
    localparam int DIVIDEND_W = 19;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic signed [THR_W-1:0] THR_RESET        = 32'sh00FF_FFFF;
    localparam logic [BPM_W-1:0]        BPM_MAX          = '1;
    localparam logic [RATE_CFG_W-1:0]   SAMPLE_RATE_RESET = 13'd250;

    // apb register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_SAMPLE_RATE = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/ecgpr_cfg.sv =====
module ecgpr_cfg
    import ecgpr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [RATE_CFG_W-1:0]   sample_rate
);

    logic [RATE_CFG_W-1:0] rate_reg, rate_next;
    logic                  hit;
    logic                  wr_en;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1:2] == REG_SAMPLE_RATE);
    assign wr_en  = psel && penable && pwrite && pready && hit;

    always_comb
    begin
        rate_next = rate_reg;
        if (wr_en)
        begin
            rate_next = pwdata[RATE_CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= SAMPLE_RATE_RESET;
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    assign prdata      = hit ? APB_DATA_W'(rate_reg) : '0;
    assign sample_rate = rate_reg;

endmodule

// ===== sv/ecgpr_div.sv =====
module ecgpr_div
    import ecgpr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output logic [DIVIDEND_W-1:0]  quotient,
    output div_stat_t              stat
);

    // restoring divider: dividend bits shift out the top of quo_reg,
    // quotient bits shift in at the bottom, one bit per cycle
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] den_reg, den_next;
    logic [DIVIDEND_W-1:0]  quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/ecg_adaptive_peak_rate_detector.sv =====
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------------------
// s_axis    | s_tvalid / s_tready       | s_tdata: filtered_sample
// m_axis    | m_tvalid / m_tready       | m_tdata: beat_detected, beats_per_minute,
//           |                           |          current_threshold
// apb       | psel, penable, pready     | paddr, pwdata, prdata: sample_rate
//
// a sample goes from accept to accept through idle, gate, evaluate and hand off (which waits
// while an untaken result fills the output register); the result register loads as hand off ends
// a sample that closes a beat also passes a divide state: the rate goes through a
// bit-serial restoring divider, one quotient bit per cycle over 19 dividend bits
// the next sample is accepted while the previous result waits in the output register
// reset (rst_n, async, active low) restores threshold 0x00FFFFFF and sample rate 250 and clears the control state
module ecg_adaptive_peak_rate_detector
    import ecgpr_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] filtered_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] beat_detected, [18:1] beats_per_minute,
                                              // [50:19] current_threshold, [55:51] zero
);

    localparam int TH7_W = THR_W + 3;
    localparam int BL_W  = THR_W + 4;
    localparam int DC_W  = THR_W + 7;

    ctl_state_t state_reg, state_next;

    logic signed [SAMPLE_WIDTH-1:0] cur_reg, cur_next;
    logic signed [TH7_W-1:0]        th7_reg, th7_next;
    logic signed [THR_W-1:0]        thr_reg, thr_next;
    logic signed [SAMPLE_WIDTH-1:0] peak_reg, peak_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic [COUNT_WIDTH-1:0]         pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0]         count_reg, count_next;
    logic                           first_done_reg, first_done_next;
    logic [BPM_W-1:0]               rate_reg, rate_next;
    logic                           beat_reg, beat_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]         out_data_reg, out_data_next;

    logic [RATE_CFG_W-1:0]          sample_rate;
    logic                           div_start;
    logic [DIVIDEND_W-1:0]          div_dividend;
    logic [COUNT_WIDTH-1:0]         div_divisor;
    logic [DIVIDEND_W-1:0]          div_quotient;
    div_stat_t                      div_stat;

    logic signed [THR_W-1:0]        gate;
    logic signed [THR_W-1:0]        cur_ext;
    logic signed [THR_W-1:0]        prev_ext;
    logic signed [TH7_W-1:0]        pk7;
    logic signed [BL_W-1:0]         blend;
    logic signed [DC_W-1:0]         decay;
    logic                           ge_gate;
    logic                           ge_peak;
    logic                           prev_ge;
    logic                           peak_pos;
    logic [COUNT_WIDTH-1:0]         rebased;

    function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    ecgpr_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .sample_rate (sample_rate)
    );

    ecgpr_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // gate = floor(7 * threshold / 8), taken from the registered 7x product
    assign gate     = th7_reg[THR_W+2:3];
    assign cur_ext  = THR_W'(cur_reg);
    assign prev_ext = THR_W'(prev_reg);
    assign pk7      = (TH7_W'(peak_reg) <<< 3) - TH7_W'(peak_reg);
    assign blend    = BL_W'(th7_reg) + BL_W'(peak_reg);
    assign decay    = (DC_W'(thr_reg) <<< 7) - DC_W'(thr_reg);
    assign ge_gate  = (cur_ext >= gate);
    assign ge_peak  = (cur_reg >= peak_reg);
    assign prev_ge  = (prev_ext >= gate);
    assign peak_pos = !peak_reg[SAMPLE_WIDTH-1] && (peak_reg != '0);
    assign rebased  = (count_reg > pos_reg) ? count_reg - pos_reg - 1'b1 : '0;

    assign div_dividend = DIVIDEND_W'(sample_rate) * DIVIDEND_W'(RATE_SCALE);
    assign div_divisor  = (pos_reg == '0) ? COUNT_WIDTH'(1) : pos_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        th7_next        = th7_reg;
        thr_next        = thr_reg;
        peak_next       = peak_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        first_done_next = first_done_reg;
        rate_next       = rate_reg;
        beat_next       = beat_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_data_next   = out_data_reg;
        div_start       = 1'b0;
        s_tready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cur_next   = s_tdata[SAMPLE_WIDTH-1:0];
                    state_next = ST_GATE;
                end
            end
            ST_GATE:
            begin
                th7_next   = (TH7_W'(thr_reg) <<< 3) - TH7_W'(thr_reg);
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                beat_next  = 1'b0;
                prev_next  = cur_reg;
                count_next = count_inc(count_reg);
                state_next = ST_DONE;
                if (ge_gate)
                begin
                    if (ge_peak)
                    begin
                        peak_next = cur_reg;
                        pos_next  = count_reg;
                    end
                    else if (!first_done_reg)
                    begin
                        // one-time snap of the threshold to 7/8 of the first peak
                        thr_next        = pk7[THR_W+2:3];
                        first_done_next = 1'b1;
                    end
                end
                else if (prev_ge && peak_pos)
                begin
                    beat_next  = 1'b1;
                    div_start  = 1'b1;
                    thr_next   = blend[THR_W+2:3];
                    peak_next  = '0;
                    count_next = count_inc(rebased);
                    state_next = ST_DIV;
                end
                else
                begin
                    thr_next  = decay[THR_W+6:7];
                    peak_next = '0;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    rate_next  = (div_quotient > DIVIDEND_W'(BPM_MAX)) ?
                                 BPM_MAX : div_quotient[BPM_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {{OUT_PAD_W{1'b0}}, thr_reg, rate_reg, beat_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            peak_reg       <= '0;
            prev_reg       <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            first_done_reg <= 1'b0;
            rate_reg       <= '0;
            beat_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            peak_reg       <= peak_next;
            prev_reg       <= prev_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            first_done_reg <= first_done_next;
            rate_reg       <= rate_next;
            beat_reg       <= beat_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        th7_reg      <= th7_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_beat_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && div_start) |=> (state_reg == ST_DIV && div_stat.busy))
        else $error("beat did not launch the divider");

    a_first_adapt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        first_done_reg |=> first_done_reg)
        else $error("first threshold adaptation flag cleared");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished result not placed in output register");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("input ready while divider still running");

endmodule
